[sv/svdp_pkg.sv]
// Shared types, codes and float helpers for the sparse vector dot product block.
package svdp_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int MATCH_W         = 11;
    localparam int QUEUE_DEPTH     = 4;
    localparam int LIMIT_W         = 33;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'h1_0000_0000;

    localparam logic [1:0] OP_FIRST  = 2'd0;
    localparam logic [1:0] OP_SECOND = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] CFG_LIMIT_FIRST  = 2'd0;
    localparam logic [1:0] CFG_LIMIT_SECOND = 2'd1;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_MERGE,
        KIND_FINISH
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [31:0] idx;
        logic [31:0] val;
    } qent_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CMP,
        BK_MUL,
        BK_NORM,
        BK_ROUND,
        BK_ADD,
        BK_OUT
    } bk_state_t;

    // Leading zero count of a 48-bit word.
    function automatic logic [5:0] lzc48(input logic [47:0] w);
        logic       found;
        logic [5:0] lz;
        found = 1'b0;
        lz    = '0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (w[i]) found = 1'b1;
                else lz = lz + 6'd1;
            end
        end
        return lz;
    endfunction

    // Round to nearest even and pack. sig[26] is the leading one,
    // value = sig / 2^26 * 2^(e - 127); sig[0] carries sticky.
    function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e,
                                            input logic [26:0] sig);
        logic [11:0] shamt;
        logic [4:0]  sh;
        logic [7:0]  base;
        logic [58:0] ext;
        logic [26:0] sig2;
        logic [23:0] m24;
        logic        rnd;
        logic [30:0] res;
        shamt = 12'd1 - e;
        if (e <= 12'sd0) begin
            sh   = (shamt > 12'd31) ? 5'd31 : shamt[4:0];
            base = 8'd0;
        end else begin
            sh   = 5'd0;
            base = e[7:0] - 8'd1;
        end
        ext  = {sig, 32'b0} >> sh;
        sig2 = {ext[58:33], ext[32] | (|ext[31:0])};
        m24  = sig2[26:3];
        rnd  = sig2[2] & ((|sig2[1:0]) | m24[0]);
        res  = {base, 23'b0} + {7'b0, m24} + {30'b0, rnd};
        if (e >= 12'sd255) return {s, 8'hFF, 23'b0};
        return {s, res};
    endfunction

endpackage

[sv/sparse_vector_dot_product_top.sv]
// Top level of the sparse vector dot product block.
// Usage: load the first vector as s_tuser = 0 items (index in s_tdata[31:0],
// float bits in s_tdata[63:32]), ascending by index, then stream the second
// vector as s_tuser = 1 items with s_tlast on the final one (or send
// s_tuser = 2 to close the pair). One result transaction follows on m_*:
// dot product, match count and buffer overflow flag. The block then clears
// its pair state and is ready for the next pair; buffered entries are
// simply overwritten.
// Flow: a first-vector entry is written to the buffer as the back end pops it.
// A second-vector entry leaves the queue, then each buffered entry compared
// takes a registered buffer read, then a compare; one more read step comes
// when the pointer runs off the end of the buffer. A match runs at most
// multiply, normalize, round, add, normalize, round through the one shared float unit.
// The 4-entry queue lets the input keep flowing while the back end works.
// A finish goes from BK_IDLE to BK_OUT; once no result is held, m_tvalid is set.
// Reset (aresetn low, synchronous) empties the queue, clears the pair state
// and sets both limits to 2^32. If m_tready stays low the result is held
// and the back end stops at its next finish; the queue then fills and
// s_tready drops. The cfg channel is always ready; write it only when idle.
module sparse_vector_dot_product_top
    import svdp_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,   // entry_index[31:0], entry_value[63:32]
    input  logic [1:0]         s_tuser,   // op
    input  logic               s_tlast,   // last
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // dot_product[31:0], match_count[42:32],
                                          // overflow[43], zero fill
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0] limit_first_reg, limit_first_next;
    logic [LIMIT_W-1:0] limit_second_reg, limit_second_next;
    logic               q_full, q_push, q_pop, q_valid;
    qent_t              q_entry, q_head;

    assign cfg_ready = 1'b1;

    always_comb begin
        limit_first_next  = limit_first_reg;
        limit_second_next = limit_second_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_LIMIT_FIRST:  limit_first_next  = cfg_data;
                CFG_LIMIT_SECOND: limit_second_next = cfg_data;
                default:          limit_first_next  = limit_first_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_first_reg  <= LIMIT_RESET;
            limit_second_reg <= LIMIT_RESET;
        end else begin
            limit_first_reg  <= limit_first_next;
            limit_second_reg <= limit_second_next;
        end
    end

    svdp_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .limit_first  (limit_first_reg),
        .limit_second (limit_second_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    svdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    svdp_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[sv/svdp_front.sv]
// Front end: accepts stream items, applies the index limits and classifies them.
module svdp_front
    import svdp_pkg::*;
(
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,   // entry_index[31:0], entry_value[63:32]
    input  logic [1:0]         s_tuser,   // op
    input  logic               s_tlast,
    input  logic [LIMIT_W-1:0] limit_first,
    input  logic [LIMIT_W-1:0] limit_second,
    input  logic               q_full,
    output logic               q_push,
    output qent_t              q_entry
);

    logic [31:0] idx;
    logic        in_first;
    logic        in_second;
    logic        take;

    assign idx       = s_tdata[31:0];
    assign in_first  = {1'b0, idx} < limit_first;
    assign in_second = {1'b0, idx} < limit_second;
    assign s_tready  = !q_full;
    assign take      = s_tvalid && !q_full;

    always_comb begin
        q_push        = 1'b0;
        q_entry.kind  = KIND_STORE;
        q_entry.fin   = 1'b0;
        q_entry.idx   = idx;
        q_entry.val   = s_tdata[63:32];
        case (s_tuser)
            OP_FIRST: begin
                q_push = take && in_first;
            end
            OP_SECOND: begin
                // over-limit entries only matter when they close the pair
                q_entry.kind = in_second ? KIND_MERGE : KIND_FINISH;
                q_entry.fin  = s_tlast;
                q_push       = take && (in_second || s_tlast);
            end
            OP_FINISH: begin
                q_entry.kind = KIND_FINISH;
                q_entry.fin  = 1'b1;
                q_push       = take;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

[sv/svdp_queue.sv]
// Small FIFO of classified items between front and back.
module svdp_queue
    import svdp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  qent_t push_entry,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output qent_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    qent_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full       = cnt_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = do_push ? wr_reg + PTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_reg] <= push_entry;
    end

endmodule

[sv/svdp_back.sv]
// Back end: buffers first-vector entries, merges second-vector entries, float MAC.
module svdp_back
    import svdp_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  qent_t       q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [31:0] idx_mem [MAX_ENTRIES];
    logic [31:0] val_mem [MAX_ENTRIES];
    logic [31:0] rd_idx_reg, rd_val_reg;
    logic        mem_we;

    bk_state_t          state_reg, state_next;
    qent_t              cur_reg, cur_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [MATCH_W-1:0] matches_reg, matches_next;
    logic               ovf_reg, ovf_next;
    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        prod_reg, prod_next;
    logic [31:0]        a_reg, a_next;
    logic [47:0]        w_reg, w_next;
    logic signed [11:0] e_reg, e_next;
    logic               s_reg, s_next;
    logic [26:0]        sig_reg, sig_next;
    logic               addp_reg, addp_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;

    // multiply operand decode
    logic        ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero;
    logic        mul_special;
    logic [31:0] mul_special_val;
    logic [7:0]  ma_e, mb_e;
    logic [23:0] ma_m, mb_m;

    // add operand decode
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic        add_special;
    logic [31:0] add_special_val;
    logic [31:0] big, sml;
    logic [7:0]  eb, es, ediff;
    logic [23:0] mb, ms;
    logic [5:0]  ash;
    logic [71:0] ys;
    logic [47:0] yal, xw, add_w;
    logic        add_zero;

    logic [5:0]  lz;
    logic [47:0] wn;
    logic [31:0] packed_res;
    logic        cnt_has_room;
    logic        idx_lt, idx_eq;

    assign cnt_has_room = cnt_reg < CNT_W'(MAX_ENTRIES);
    assign idx_lt       = rd_idx_reg < cur_reg.idx;
    assign idx_eq       = rd_idx_reg == cur_reg.idx;

    always_comb begin
        ma_e    = a_reg[30:23];
        mb_e    = cur_reg.val[30:23];
        ma_m    = {ma_e != 8'd0, a_reg[22:0]};
        mb_m    = {mb_e != 8'd0, cur_reg.val[22:0]};
        ma_nan  = (ma_e == 8'hFF) && (a_reg[22:0] != '0);
        mb_nan  = (mb_e == 8'hFF) && (cur_reg.val[22:0] != '0);
        ma_inf  = (ma_e == 8'hFF) && (a_reg[22:0] == '0);
        mb_inf  = (mb_e == 8'hFF) && (cur_reg.val[22:0] == '0);
        ma_zero = a_reg[30:0] == '0;
        mb_zero = cur_reg.val[30:0] == '0;
        mul_special     = 1'b1;
        mul_special_val = '0;
        if (ma_nan) mul_special_val = a_reg | FP_QUIET_BIT;
        else if (mb_nan) mul_special_val = cur_reg.val | FP_QUIET_BIT;
        else if ((ma_inf && mb_zero) || (mb_inf && ma_zero)) mul_special_val = FP_DEFAULT_NAN;
        else if (ma_inf || mb_inf)
            mul_special_val = {a_reg[31] ^ cur_reg.val[31], 8'hFF, 23'b0};
        else if (ma_zero || mb_zero) mul_special_val = {a_reg[31] ^ cur_reg.val[31], 31'b0};
        else mul_special = 1'b0;
    end

    always_comb begin
        x_nan  = (acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] != '0);
        y_nan  = (prod_reg[30:23] == 8'hFF) && (prod_reg[22:0] != '0);
        x_inf  = (acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] == '0);
        y_inf  = (prod_reg[30:23] == 8'hFF) && (prod_reg[22:0] == '0);
        x_zero = acc_reg[30:0] == '0;
        y_zero = prod_reg[30:0] == '0;
        add_special     = 1'b1;
        add_special_val = '0;
        if (x_nan) add_special_val = acc_reg | FP_QUIET_BIT;
        else if (y_nan) add_special_val = prod_reg | FP_QUIET_BIT;
        else if (x_inf && y_inf && (acc_reg[31] != prod_reg[31])) add_special_val = FP_DEFAULT_NAN;
        else if (x_inf) add_special_val = acc_reg;
        else if (y_inf) add_special_val = prod_reg;
        else if (x_zero && y_zero) add_special_val = {acc_reg[31] & prod_reg[31], 31'b0};
        else if (x_zero) add_special_val = prod_reg;
        else if (y_zero) add_special_val = acc_reg;
        else add_special = 1'b0;

        // larger magnitude first, then align the smaller one with sticky
        big   = (acc_reg[30:0] >= prod_reg[30:0]) ? acc_reg : prod_reg;
        sml   = (acc_reg[30:0] >= prod_reg[30:0]) ? prod_reg : acc_reg;
        eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mb    = {big[30:23] != 8'd0, big[22:0]};
        ms    = {sml[30:23] != 8'd0, sml[22:0]};
        ediff = eb - es;
        ash   = (ediff > 8'd63) ? 6'd63 : ediff[5:0];
        ys    = {1'b0, ms, 47'b0} >> ash;
        yal   = ys[71:24] | {47'b0, |ys[23:0]};
        xw    = {1'b0, mb, 23'b0};
        add_w = (acc_reg[31] == prod_reg[31]) ? xw + yal : xw - yal;
        add_zero = add_w == '0;
    end

    always_comb begin
        lz         = lzc48(w_reg);
        wn         = w_reg << lz;
        packed_res = fp_pack(s_reg, e_reg, sig_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    case (q_head.kind)
                        KIND_MERGE:  state_next = BK_READ;
                        KIND_FINISH: state_next = BK_OUT;
                        default:     state_next = BK_IDLE;
                    endcase
                end
            end
            BK_READ: begin
                if (ptr_reg < cnt_reg) state_next = BK_CMP;
                else state_next = cur_reg.fin ? BK_OUT : BK_IDLE;
            end
            BK_CMP: begin
                if (idx_lt) state_next = BK_READ;
                else if (idx_eq) state_next = BK_MUL;
                else state_next = cur_reg.fin ? BK_OUT : BK_IDLE;
            end
            BK_MUL: state_next = mul_special ? BK_ADD : BK_NORM;
            BK_NORM: state_next = BK_ROUND;
            BK_ROUND: begin
                if (!addp_reg) state_next = BK_ADD;
                else state_next = cur_reg.fin ? BK_OUT : BK_IDLE;
            end
            BK_ADD: begin
                if (add_special || add_zero) state_next = cur_reg.fin ? BK_OUT : BK_IDLE;
                else state_next = BK_NORM;
            end
            BK_OUT: begin
                if (!m_tvalid_reg) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        matches_next  = matches_reg;
        ovf_next      = ovf_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        a_next        = a_reg;
        w_next        = w_reg;
        e_next        = e_reg;
        s_next        = s_reg;
        sig_next      = sig_reg;
        addp_next     = addp_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (q_head.kind == KIND_STORE) begin
                        if (cnt_has_room) begin
                            mem_we   = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            BK_CMP: begin
                if (idx_lt) begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end else if (idx_eq) begin
                    ptr_next     = ptr_reg + CNT_W'(1);
                    matches_next = matches_reg + MATCH_W'(1);
                    a_next       = rd_val_reg;
                end
            end
            BK_MUL: begin
                prod_next = mul_special_val;
                w_next    = ma_m * mb_m;
                e_next    = 12'({4'b0, (ma_e == 8'd0) ? 8'd1 : ma_e})
                          + 12'({4'b0, (mb_e == 8'd0) ? 8'd1 : mb_e}) - 12'd126;
                s_next    = a_reg[31] ^ cur_reg.val[31];
                addp_next = 1'b0;
            end
            BK_NORM: begin
                sig_next = {wn[47:22], |wn[21:0]};
                e_next   = e_reg - 12'({6'b0, lz});
            end
            BK_ROUND: begin
                if (addp_reg) acc_next = packed_res;
                else prod_next = packed_res;
            end
            BK_ADD: begin
                if (add_special) acc_next = add_special_val;
                else if (add_zero) acc_next = '0;
                w_next    = add_w;
                e_next    = 12'({4'b0, eb}) + 12'd1;
                s_next    = big[31];
                addp_next = 1'b1;
            end
            BK_OUT: begin
                if (!m_tvalid_reg) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, ovf_reg, matches_reg, acc_reg};
                    cnt_next      = '0;
                    ptr_next      = '0;
                    matches_next  = '0;
                    ovf_next      = 1'b0;
                    acc_next      = '0;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            matches_reg  <= '0;
            ovf_reg      <= 1'b0;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            matches_reg  <= matches_next;
            ovf_reg      <= ovf_next;
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        prod_reg    <= prod_next;
        a_reg       <= a_next;
        w_reg       <= w_next;
        e_reg       <= e_next;
        s_reg       <= s_next;
        sig_reg     <= sig_next;
        addp_reg    <= addp_next;
        m_tdata_reg <= m_tdata_next;
    end

    // entry buffer: one write port, one registered read at the merge pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            idx_mem[cnt_reg[ADDR_W-1:0]] <= q_head.idx;
            val_mem[cnt_reg[ADDR_W-1:0]] <= q_head.val;
        end
        rd_idx_reg <= idx_mem[ptr_reg[ADDR_W-1:0]];
        rd_val_reg <= val_mem[ptr_reg[ADDR_W-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= cnt_reg)
        else $error("merge pointer passed fill count");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond buffer depth");

    a_mul_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_MUL) |-> ($past(state_reg) == BK_CMP))
        else $error("multiply entered without a compare");

    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_MUL) |-> (matches_reg == $past(matches_reg) + MATCH_W'(1)))
        else $error("match not counted");

endmodule
